// ===== rtl/fks_pkg.sv =====
`default_nettype none

package fks_pkg;

   localparam int DEPTH_DEFAULT        = 16;
   localparam int KEY_BITS_DEFAULT     = 16;
   localparam int PAYLOAD_BITS_DEFAULT = 32;

   localparam int FUNC_BITS        = 2;
   localparam int STATUS_BITS      = 2;
   localparam int OUT_KEY_BITS     = 16;
   localparam int OUT_PAYLOAD_BITS = 32;
   localparam int FILL_BITS        = 5;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_ENQ  = 2'd0,
      FUNC_DEQ  = 2'd1,
      FUNC_SORT = 2'd2
   } func_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEQ,
      ST_FETCH,
      ST_LOAD,
      ST_CMP,
      ST_PLACE,
      ST_COPY_RD,
      ST_COPY_WR
   } state_type;

   typedef struct packed {
      status_type                  status;
      logic [OUT_KEY_BITS-1:0]     out_key;
      logic [OUT_PAYLOAD_BITS-1:0] out_payload;
      logic [FILL_BITS-1:0]        fill_count;
      logic                        is_empty;
      logic                        is_full;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/fks_ram.sv =====
`default_nettype none

module fks_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/fks_rsp_buf.sv =====
`default_nettype none

// Two-entry result buffer: output register plus skid register.
module fks_rsp_buf
   import fks_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   input  wire result_type in_res,
   output logic            has_room,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output result_type      rsp_res
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       take;

   assign take = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_in       = in_res;
            skid_valid_in = in_valid;
         end else begin
            out_in       = in_res;
            out_valid_in = in_valid;
         end
      end else if (in_valid) begin
         skid_in       = in_res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign has_room  = !skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_res   = out_ff;

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> !(skid_valid_ff && out_valid_ff && rsp_stall))
      else $error("result beat arrived with both buffer entries held");

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_skid_drains_first: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && take) |=> (out_valid_ff && out_ff == $past(skid_ff)))
      else $error("skid entry not moved to output in order");
`endif

endmodule

`default_nettype wire

// ===== rtl/fifo_with_key_sort_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake           Beat
// req_      in         req_valid/req_stall func, item_key, item_payload
// rsp_      out        rsp_valid/rsp_stall status, out_key, out_payload, fill_count,
//                                          is_empty, is_full
//
// Enqueue, an unused func and any rejected op answer from ST_IDLE; dequeue passes
// through ST_DEQ for the registered entry RAM read. Sort of n entries: accept, then
// each entry fetched (ST_FETCH, ST_LOAD) and inserted into a scratch RAM (ST_CMP,
// ST_PLACE; the first at ST_LOAD), then copied back (ST_COPY_RD, ST_COPY_WR). Reset
// clears state, head and count only; entries are not cleared.
// A result sits in a two-entry buffer; a stalled rsp_ holds off req_ once both are used.
module fifo_with_key_sort_unit
   import fks_pkg::*;
#(
   parameter int DEPTH        = DEPTH_DEFAULT,
   parameter int KEY_BITS     = KEY_BITS_DEFAULT,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [FUNC_BITS-1:0]        req_func,
   input  wire logic [KEY_BITS-1:0]         req_item_key,
   input  wire logic [PAYLOAD_BITS-1:0]     req_item_payload,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic      [STATUS_BITS-1:0]      rsp_status,
   output logic      [OUT_KEY_BITS-1:0]     rsp_out_key,
   output logic      [OUT_PAYLOAD_BITS-1:0] rsp_out_payload,
   output logic      [FILL_BITS-1:0]        rsp_fill_count,
   output logic                             rsp_is_empty,
   output logic                             rsp_is_full
);

   localparam int AW = $clog2(DEPTH);
   localparam int SW = AW + 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = KEY_BITS + PAYLOAD_BITS;

   function automatic logic [AW-1:0] wrap_slot(input logic [SW-1:0] sum);
      logic [SW-1:0] adj;
      adj = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;
      return adj[AW-1:0];
   endfunction

   state_type      state_ff, state_in;
   logic [AW-1:0]  head_ff, head_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [AW-1:0]  pos_ff, pos_in;
   logic [EW-1:0]  new_ff, new_in;

   logic           m_we;
   logic [AW-1:0]  m_waddr, m_raddr;
   logic [EW-1:0]  m_wdata, m_rdata;
   logic           s_we;
   logic [AW-1:0]  s_waddr, s_raddr;
   logic [EW-1:0]  s_wdata, s_rdata;

   logic           accept;
   logic           room;
   logic           res_valid;
   result_type     res;
   result_type     rsp_res;
   logic [CW-1:0]  idx_inc;
   logic           last_elem;
   logic           sort_done;
   logic           shift_up;

   assign accept    = req_valid && !req_stall;
   assign req_stall = !((state_ff == ST_IDLE) && room);
   assign idx_inc   = idx_ff + CW'(1);
   assign last_elem = (idx_inc == cnt_ff);
   assign sort_done = (state_ff == ST_COPY_WR) && last_elem;
   assign shift_up  = s_rdata[EW-1 -: KEY_BITS] > new_ff[EW-1 -: KEY_BITS];

   fks_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_entry_ram (
      .clock (clock),
      .we    (m_we),
      .waddr (m_waddr),
      .wdata (m_wdata),
      .raddr (m_raddr),
      .rdata (m_rdata)
   );

   fks_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_scratch_ram (
      .clock (clock),
      .we    (s_we),
      .waddr (s_waddr),
      .wdata (s_wdata),
      .raddr (s_raddr),
      .rdata (s_rdata)
   );

   fks_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_res    (res),
      .has_room  (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_res   (rsp_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_DEQ && cnt_ff != '0) begin
                  state_in = ST_DEQ;
               end else if (req_func == FUNC_SORT && cnt_ff != '0) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_DEQ:   state_in = ST_IDLE;
         ST_FETCH: state_in = ST_LOAD;
         ST_LOAD: begin
            if (idx_ff != '0) begin
               state_in = ST_CMP;
            end else begin
               state_in = last_elem ? ST_COPY_RD : ST_FETCH;
            end
         end
         ST_CMP: begin
            if (shift_up) begin
               state_in = (pos_ff == AW'(1)) ? ST_PLACE : ST_CMP;
            end else begin
               state_in = last_elem ? ST_COPY_RD : ST_FETCH;
            end
         end
         ST_PLACE:   state_in = last_elem ? ST_COPY_RD : ST_FETCH;
         ST_COPY_RD: state_in = ST_COPY_WR;
         ST_COPY_WR: state_in = last_elem ? ST_IDLE : ST_COPY_RD;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      head_in   = head_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      new_in    = new_ff;
      m_we      = 1'b0;
      m_waddr   = wrap_slot(SW'(head_ff) + SW'(cnt_ff));
      m_wdata   = {req_item_key, req_item_payload};
      m_raddr   = head_ff;
      s_we      = 1'b0;
      s_waddr   = pos_ff;
      s_wdata   = new_ff;
      s_raddr   = pos_ff - AW'(1);
      res_valid = 1'b0;
      res.status      = STS_OK;
      res.out_key     = '0;
      res.out_payload = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  FUNC_ENQ: begin
                     res_valid = 1'b1;
                     if (cnt_ff == CW'(DEPTH)) begin
                        res.status = STS_FULL;
                     end else begin
                        m_we   = 1'b1;
                        cnt_in = cnt_ff + CW'(1);
                     end
                  end
                  FUNC_DEQ: begin
                     if (cnt_ff == '0) begin
                        res_valid  = 1'b1;
                        res.status = STS_EMPTY;
                     end else begin
                        head_in = wrap_slot(SW'(head_ff) + SW'(1));
                        cnt_in  = cnt_ff - CW'(1);
                     end
                  end
                  FUNC_SORT: begin
                     idx_in = '0;
                     if (cnt_ff == '0) begin
                        head_in   = '0;
                        res_valid = 1'b1;
                     end
                  end
                  default: res_valid = 1'b1;
               endcase
            end
         end
         ST_DEQ: begin
            res_valid       = 1'b1;
            res.out_key     = OUT_KEY_BITS'(m_rdata[EW-1 -: KEY_BITS]);
            res.out_payload = OUT_PAYLOAD_BITS'(m_rdata[PAYLOAD_BITS-1:0]);
         end
         ST_FETCH: begin
            m_raddr = wrap_slot(SW'(head_ff) + SW'(idx_ff));
         end
         ST_LOAD: begin
            new_in = m_rdata;
            if (idx_ff == '0) begin
               s_we    = 1'b1;
               s_waddr = '0;
               s_wdata = m_rdata;
               idx_in  = last_elem ? '0 : idx_inc;
            end else begin
               pos_in  = idx_ff[AW-1:0];
               s_raddr = idx_ff[AW-1:0] - AW'(1);
            end
         end
         ST_CMP: begin
            s_we = 1'b1;
            if (shift_up) begin
               // move the larger entry up one place, look one further down
               s_wdata = s_rdata;
               pos_in  = pos_ff - AW'(1);
               s_raddr = pos_ff - AW'(2);
            end else begin
               idx_in = last_elem ? '0 : idx_inc;
            end
         end
         ST_PLACE: begin
            s_we   = 1'b1;
            idx_in = last_elem ? '0 : idx_inc;
         end
         ST_COPY_RD: begin
            s_raddr = idx_ff[AW-1:0];
         end
         ST_COPY_WR: begin
            m_we    = 1'b1;
            m_waddr = idx_ff[AW-1:0];
            m_wdata = s_rdata;
            idx_in  = idx_inc;
            if (last_elem) begin
               head_in   = '0;
               res_valid = 1'b1;
            end
         end
         default: ;
      endcase

      res.fill_count = FILL_BITS'(cnt_in);
      res.is_empty   = (cnt_in == '0);
      res.is_full    = (cnt_in == CW'(DEPTH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         cnt_ff   <= cnt_in;
      end
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      new_ff <= new_in;
   end

   assign rsp_status      = rsp_res.status;
   assign rsp_out_key     = rsp_res.out_key;
   assign rsp_out_payload = rsp_res.out_payload;
   assign rsp_fill_count  = rsp_res.fill_count;
   assign rsp_is_empty    = rsp_res.is_empty;
   assign rsp_is_full     = rsp_res.is_full;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_full_enq_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == FUNC_ENQ && cnt_ff == CW'(DEPTH))
      |=> ($stable(cnt_ff) && $stable(head_ff)))
      else $error("rejected enqueue changed queue state");

   a_sort_rebases: assert property (@(posedge clock) disable iff (reset)
      sort_done |=> (head_ff == '0 && state_ff == ST_IDLE))
      else $error("sort did not leave head at slot zero");

   a_cmp_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (pos_ff != '0 && CW'(pos_ff) <= idx_ff))
      else $error("insertion position out of range");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
module testbench;
   import fks_pkg::*;

   localparam int                    QDEPTH      = DEPTH_DEFAULT;
   localparam int                    RAND_ITEMS  = 1250;
   localparam int                    CYCLE_LIMIT = 1200000;
   localparam int                    TAIL_CYCLES = 32;
   localparam logic [FUNC_BITS-1:0]  FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [FUNC_BITS-1:0]            op;
      logic [KEY_BITS_DEFAULT-1:0]     key;
      logic [PAYLOAD_BITS_DEFAULT-1:0] pay;
      bit                              typed;
      result_type                      want;
   } script_row;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [FUNC_BITS-1:0]            req_func = FUNC_ENQ;
   logic [KEY_BITS_DEFAULT-1:0]     req_item_key = '0;
   logic [PAYLOAD_BITS_DEFAULT-1:0] req_item_payload = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [STATUS_BITS-1:0]          rsp_status;
   logic [OUT_KEY_BITS-1:0]         rsp_out_key;
   logic [OUT_PAYLOAD_BITS-1:0]     rsp_out_payload;
   logic [FILL_BITS-1:0]            rsp_fill_count;
   logic                            rsp_is_empty;
   logic                            rsp_is_full;

   // shadow copy of the queue
   logic [KEY_BITS_DEFAULT-1:0]     q_keys [QDEPTH];
   logic [PAYLOAD_BITS_DEFAULT-1:0] q_pays [QDEPTH];
   int                              q_head = 0;
   int                              q_count = 0;

   result_type                      pending_rsp [$];
   script_row                       plan [$];

   int                              err_count = 0;
   int                              cycle_count = 0;
   int                              hold_left = 0;
   bit                              calm = 1'b0;
   int                              n_reqs = 0;
   int                              n_sorts = 0;
   int                              n_full = 0;
   int                              n_empty = 0;
   int                              max_fill = 0;

   fifo_with_key_sort_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_item_key    (req_item_key),
      .req_item_payload(req_item_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_payload (rsp_out_payload),
      .rsp_fill_count  (rsp_fill_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int draw_wait();
      if (calm)
         return 0;
      return $urandom_range(0, 6);
   endfunction

   // Applies one operation to the shadow queue and returns the response it gives.
   function automatic result_type fifo_apply_op(input logic [FUNC_BITS-1:0] op,
                                                input logic [KEY_BITS_DEFAULT-1:0] k,
                                                input logic [PAYLOAD_BITS_DEFAULT-1:0] p);
      result_type                      r;
      logic [KEY_BITS_DEFAULT-1:0]     tk [QDEPTH];
      logic [PAYLOAD_BITS_DEFAULT-1:0] tp [QDEPTH];
      logic [KEY_BITS_DEFAULT-1:0]     sk;
      logic [PAYLOAD_BITS_DEFAULT-1:0] sp;
      int                              slot;
      int                              j;

      r = '0;
      r.status = STS_OK;
      if (op == FUNC_ENQ) begin
         if (q_count >= QDEPTH) begin
            r.status = STS_FULL;
            n_full++;
         end else begin
            slot = (q_head + q_count) % QDEPTH;
            q_keys[slot] = k;
            q_pays[slot] = p;
            q_count++;
         end
      end else if (op == FUNC_DEQ) begin
         if (q_count == 0) begin
            r.status = STS_EMPTY;
            n_empty++;
         end else begin
            r.out_key = q_keys[q_head];
            r.out_payload = q_pays[q_head];
            q_head = (q_head + 1) % QDEPTH;
            q_count--;
         end
      end else if (op == FUNC_SORT) begin
         n_sorts++;
         for (int i = 0; i < q_count; i++) begin
            slot = (q_head + i) % QDEPTH;
            tk[i] = q_keys[slot];
            tp[i] = q_pays[slot];
         end
         // strict less-than keeps equal keys in arrival order
         for (int i = 1; i < q_count; i++) begin
            j = i;
            while (j > 0 && tk[j] < tk[j-1]) begin
               sk = tk[j];
               sp = tp[j];
               tk[j] = tk[j-1];
               tp[j] = tp[j-1];
               tk[j-1] = sk;
               tp[j-1] = sp;
               j--;
            end
         end
         for (int i = 0; i < q_count; i++) begin
            q_keys[i] = tk[i];
            q_pays[i] = tp[i];
         end
         q_head = 0;
      end
      r.fill_count = FILL_BITS'(q_count);
      r.is_empty = (q_count == 0);
      r.is_full = (q_count >= QDEPTH);
      if (q_count > max_fill)
         max_fill = q_count;
      return r;
   endfunction

   task automatic add_row(input logic [FUNC_BITS-1:0] op,
                          input logic [KEY_BITS_DEFAULT-1:0] k,
                          input logic [PAYLOAD_BITS_DEFAULT-1:0] p,
                          input bit typed, input result_type want);
      script_row row;

      row.op = op;
      row.key = k;
      row.pay = p;
      row.typed = typed;
      row.want = want;
      plan.push_back(row);
   endtask

   // Presents one request beat and holds it until accepted.
   task automatic send_req(input logic [FUNC_BITS-1:0] op,
                           input logic [KEY_BITS_DEFAULT-1:0] k,
                           input logic [PAYLOAD_BITS_DEFAULT-1:0] p,
                           input bit typed, input result_type want);
      int         gap;
      result_type predicted;

      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= op;
      req_item_key <= k;
      req_item_payload <= p;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predicted = fifo_apply_op(op, k, p);
      pending_rsp.push_back(typed ? want : predicted);
      n_reqs++;
   endtask

   function automatic logic [KEY_BITS_DEFAULT-1:0] pick_key();
      case ($urandom_range(0, 3))
         0: return KEY_BITS_DEFAULT'($urandom_range(0, 7));
         1: return KEY_BITS_DEFAULT'($urandom);
         2: begin
            case ($urandom_range(0, 3))
               0: return 16'h0000;
               1: return 16'hFFFF;
               2: return 16'h8000;
               default: return 16'h7FFF;
            endcase
         end
         default: return KEY_BITS_DEFAULT'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [PAYLOAD_BITS_DEFAULT-1:0] pick_pay();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Weighted op choice; kind 0 fills, 1 drains, 2 mixes.
   function automatic logic [FUNC_BITS-1:0] pick_op(input int kind);
      int r;

      r = $urandom_range(0, 99);
      case (kind)
         0: begin
            if (r < 85) return FUNC_ENQ;
            if (r < 95) return FUNC_DEQ;
            if (r < 98) return FUNC_SORT;
            return FUNC_UNUSED;
         end
         1: begin
            if (r < 80) return FUNC_DEQ;
            if (r < 92) return FUNC_ENQ;
            if (r < 97) return FUNC_SORT;
            return FUNC_UNUSED;
         end
         default: begin
            if (r < 45) return FUNC_ENQ;
            if (r < 85) return FUNC_DEQ;
            if (r < 95) return FUNC_SORT;
            return FUNC_UNUSED;
         end
      endcase
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count % 97 == 0)
         calm <= ($urandom_range(0, 3) == 0);
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Response-side back-pressure, redrawn after each beat and sometimes while idle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            hold_left = draw_wait();
         else if (!rsp_valid && hold_left == 0 && $urandom_range(0, 7) == 0)
            hold_left = draw_wait();
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      result_type want;

      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("response beat with nothing outstanding");
            err_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               err_count++;
            end
            if (rsp_out_key !== want.out_key) begin
               $error("out_key: expected %h, got %h", want.out_key, rsp_out_key);
               err_count++;
            end
            if (rsp_out_payload !== want.out_payload) begin
               $error("out_payload: expected %h, got %h", want.out_payload, rsp_out_payload);
               err_count++;
            end
            if (rsp_fill_count !== want.fill_count) begin
               $error("fill_count: expected %0d, got %0d", want.fill_count, rsp_fill_count);
               err_count++;
            end
            if (rsp_is_empty !== want.is_empty) begin
               $error("is_empty: expected %0b, got %0b", want.is_empty, rsp_is_empty);
               err_count++;
            end
            if (rsp_is_full !== want.is_full) begin
               $error("is_full: expected %0b, got %0b", want.is_full, rsp_is_full);
               err_count++;
            end
         end
      end
   end

   initial begin
      logic [KEY_BITS_DEFAULT-1:0]     k;
      logic [PAYLOAD_BITS_DEFAULT-1:0] p;
      int                              issued;
      int                              burst;
      int                              kind;

      // empty queue right after reset
      add_row(FUNC_DEQ,    '0, '0, 1, '{STS_EMPTY, '0, '0, 5'd0, 1'b1, 1'b0});
      add_row(FUNC_SORT,   '0, '0, 1, '{STS_OK,    '0, '0, 5'd0, 1'b1, 1'b0});
      add_row(FUNC_UNUSED, '1, '1, 1, '{STS_OK,    '0, '0, 5'd0, 1'b1, 1'b0});
      // one entry at the field extremes, sorted alone, then popped
      add_row(FUNC_ENQ,    '1, '1, 1, '{STS_OK,    '0, '0, 5'd1, 1'b0, 1'b0});
      add_row(FUNC_SORT,   '0, '0, 1, '{STS_OK,    '0, '0, 5'd1, 1'b0, 1'b0});
      add_row(FUNC_DEQ,    '0, '0, 1, '{STS_OK,    16'hFFFF, 32'hFFFF_FFFF, 5'd0, 1'b1, 1'b0});
      // fill to the brim across the wrap, with repeated keys
      for (int i = 0; i < QDEPTH; i++) begin
         k = KEY_BITS_DEFAULT'(((QDEPTH - 1 - i) % 5) * 16'h3000);
         if (i == 7)
            k = 16'hFFFF;
         p = (i == 0) ? 32'h0 : {16'hC0DE, 16'(i)};
         if (i == QDEPTH - 1)
            p = 32'hFFFF_FFFF;
         add_row(FUNC_ENQ, k, p, 0, '0);
      end
      add_row(FUNC_ENQ,    16'h1234, 32'h5678_9ABC, 1,
              '{STS_FULL, '0, '0, 5'(QDEPTH), 1'b0, 1'b1});
      add_row(FUNC_SORT,   '0, '0, 1, '{STS_OK, '0, '0, 5'(QDEPTH), 1'b0, 1'b1});
      add_row(FUNC_DEQ,    '0, '0, 0, '0);
      add_row(FUNC_UNUSED, '0, '0, 1, '{STS_OK, '0, '0, 5'(QDEPTH - 1), 1'b0, 1'b0});

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         send_req(plan[i].op, plan[i].key, plan[i].pay, plan[i].typed, plan[i].want);

      issued = 0;
      while (issued < RAND_ITEMS) begin
         burst = $urandom_range(1, 20);
         kind = $urandom_range(0, 2);
         for (int b = 0; b < burst; b++) begin
            send_req(pick_op(kind), pick_key(), pick_pay(), 0, '0);
            issued++;
         end
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d requests in %0d cycles: %0d sorts, %0d full rejects,",
               n_reqs, cycle_count, n_sorts, n_full);
      $display("%0d empty dequeues, peak fill %0d of %0d.", n_empty, max_fill, QDEPTH);
      if (err_count == 0 && pending_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== fifo_with_key_sort_unit.f =====
rtl/fks_pkg.sv
rtl/fks_ram.sv
rtl/fks_rsp_buf.sv
rtl/fifo_with_key_sort_unit.sv
tb/sv/testbench.sv
